// File: src/vfbq_pkg.sv
// Package for the capture frame buffer queue.
// Holds operation codes, status codes and buffer states; no dependencies.
`default_nettype none
package vfbq_pkg;

	// Operation codes carried by an input item.
	typedef enum logic [2:0] {
		OP_QUEUE   = 3'd0,
		OP_DEQUEUE = 3'd1,
		OP_QUERY   = 3'd2,
		OP_POLL    = 3'd3,
		OP_FDONE   = 3'd4,
		OP_CANCEL  = 3'd5,
		OP_ENABLE  = 3'd6,
		OP_DISABLE = 3'd7
	} op_t;

	// Status codes returned with a result item.
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_INVALID    = 3'd1;
	localparam logic [2:0] ST_NODEV      = 3'd2;
	localparam logic [2:0] ST_WOULDBLOCK = 3'd3;
	localparam logic [2:0] ST_IOERR      = 3'd4;
	localparam logic [2:0] ST_BUSY       = 3'd5;
	localparam logic [2:0] ST_NOBUF      = 3'd6;

	// Per-buffer state.
	typedef enum logic [1:0] {
		BUF_IDLE   = 2'd0,
		BUF_QUEUED = 2'd1,
		BUF_DONE   = 2'd2,
		BUF_ERROR  = 2'd3
	} buf_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_COUNT  = 2'd0;
	localparam logic [1:0] REG_LENGTH = 2'd1;
	localparam logic [1:0] REG_DROP   = 2'd2;

	// Sequencer states.
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RD   = 5'b00010,
		S_EX   = 5'b00100,
		S_WALK = 5'b01000,
		S_FIN  = 5'b10000
	} seq_t;

endpackage
`default_nettype wire

// File: src/video_frame_buffer_queue_core.sv
// Top level of the capture frame buffer queue: sequencer, FIFO memories,
// buffer state and fill/sequence memory. Depends on vfbq_pkg.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  command | start, opcode, buffer_index, ...; busy out | in
//  result  | done, status, result_index, ...           | out
//  config  | cfg_we, cfg_index, cfg_data               | in
//
// Most operations go from the accepting edge to the edge that takes the done
// strobe through FIFO head read, buffer memory read, and execute with the
// result register. Cancel and disable add a walk over the fill FIFO, which
// reads its entries in turn through the single read port of the fill FIFO
// memory. Reset clears all control state; the buffer memory uses valid bits,
// so there is no clearing pass. The receiver cannot stall: each result item
// is shown for one cycle.
`default_nettype none
module video_frame_buffer_queue_core #(
	parameter int NUM_BUFFERS = 16,
	parameter int LENGTH_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  opcode,
	input  wire logic [3:0]  buffer_index,
	input  wire logic        kind_ok,
	input  wire logic [23:0] bytes_filled,
	input  wire logic        frame_error,
	input  wire logic        disconnect,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data,
	output logic             done,
	output logic [2:0]       status,
	output logic [3:0]       result_index,
	output logic             index_valid,
	output logic [23:0]      filled_bytes,
	output logic [31:0]      frame_sequence,
	output logic             flag_done,
	output logic             flag_queued,
	output logic             poll_readable,
	output logic             poll_error
);
	import vfbq_pkg::*;

	localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam int LW = $clog2(NUM_BUFFERS + 1);
	localparam int LB = LENGTH_BITS;
	localparam int DW = 32 + LB;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BUFFERS - 1);
	localparam logic [LW-1:0] FULL_LVL = LW'(NUM_BUFFERS);

	// Configuration registers.
	logic [4:0]  count_q;
	logic [23:0] flen_q;
	logic        drop_q;

	// Control state.
	seq_t           state_q;
	logic [IW-1:0]  main_head_q, fill_head_q;
	logic [LW-1:0]  main_lvl_q, fill_lvl_q;
	logic [31:0]    seqc_q;
	logic           stream_q, disc_dev_q;
	buf_t           bstate_q [NUM_BUFFERS];
	logic [NUM_BUFFERS-1:0] vld_q;

	// Latched item.
	op_t         op_q;
	logic [3:0]  idx_q;
	logic        kind_q, ferr_q, disc_q;
	logic [LB-1:0] bytes_q;

	// Pipeline through the read stages.
	logic [IW-1:0] b_s2;
	buf_t          st_s2;
	logic          dvld_s2;

	// Walk over the fill FIFO.
	logic [LW-1:0] wk_q;
	logic [IW-1:0] wp_q;
	logic          pend_s1;

	// Memories.
	logic [IW-1:0] main_mem [NUM_BUFFERS];
	logic [IW-1:0] fill_mem [NUM_BUFFERS];
	logic [DW-1:0] dat_mem  [NUM_BUFFERS];
	logic [IW-1:0] main_rd, fill_rd;
	logic [DW-1:0] dat_rd;
	logic [IW-1:0] fill_raddr;

	// Helper conversions.
	logic [IW+3:0]  idx_x;
	logic [IW-1:0]  idx_w;
	logic [LB+23:0] bytes_x;
	logic [7:0]     eff_cnt;
	logic           idx_ok;

	assign idx_x   = {{IW{1'b0}}, idx_q};
	assign idx_w   = idx_x[IW-1:0];
	assign bytes_x = {{LB{1'b0}}, bytes_filled};
	assign eff_cnt = ({3'b0, count_q} < 8'(NUM_BUFFERS)) ? {3'b0, count_q} : 8'(NUM_BUFFERS);
	assign idx_ok  = {4'b0, idx_q} < eff_cnt;

	function automatic logic [IW-1:0] inc_wrap(input logic [IW-1:0] h);
		inc_wrap = (h == LAST_IDX) ? '0 : h + 1'b1;
	endfunction

	function automatic logic [IW-1:0] tail_of(input logic [IW-1:0] h, input logic [LW-1:0] l);
		logic [IW+LW:0] s;
		s = {{(LW+1){1'b0}}, h} + {{(IW+1){1'b0}}, l};
		if (s >= (IW+LW+1)'(NUM_BUFFERS))
			s = s - (IW+LW+1)'(NUM_BUFFERS);
		tail_of = s[IW-1:0];
	endfunction

	function automatic logic [3:0] idx4(input logic [IW-1:0] b);
		logic [IW+3:0] t;
		t = {4'b0, b};
		idx4 = t[3:0];
	endfunction

	function automatic logic [23:0] len24(input logic [LB-1:0] v);
		logic [LB+23:0] t;
		t = {24'b0, v};
		len24 = t[23:0];
	endfunction

	// Fill FIFO read address: head at start, next entry in the read stage, walk pointer.
	always_comb begin
		case (state_q)
			S_RD:    fill_raddr = inc_wrap(fill_head_q);
			S_WALK:  fill_raddr = wp_q;
			default: fill_raddr = fill_head_q;
		endcase
	end

	// Buffer selected in the read stage.
	logic [IW-1:0] b_sel;
	always_comb begin
		case (op_q)
			OP_DEQUEUE, OP_POLL: b_sel = main_rd;
			OP_FDONE:            b_sel = fill_rd;
			default:             b_sel = idx_w;
		endcase
	end

	// Execute stage decisions.
	logic [31:0]    seq_r;
	logic [LB-1:0]  fill_r;
	logic [LB-1:0]  flen_m;
	logic [LB+23:0] flen_x;
	logic [2:0]     o_status;
	logic [3:0]     o_idx;
	logic           o_iv, o_fd, o_fq, o_pr, o_pe;
	logic [23:0]    o_fill;
	logic [31:0]    o_seq;
	logic           st_we, dat_we, push, main_pop, fill_pop, seq_inc, go_walk;
	logic           en_set;
	buf_t           st_wv;
	logic [DW-1:0]  dat_wd;

	assign seq_r  = dvld_s2 ? dat_rd[DW-1:LB] : '0;
	assign fill_r = dvld_s2 ? dat_rd[LB-1:0] : '0;
	assign flen_x = {{LB{1'b0}}, flen_q};
	assign flen_m = flen_x[LB-1:0];

	always_comb begin
		o_status = ST_OK;
		o_idx    = '0;
		o_iv     = 1'b0;
		o_fill   = '0;
		o_seq    = '0;
		o_fd     = 1'b0;
		o_fq     = 1'b0;
		o_pr     = 1'b0;
		o_pe     = 1'b0;
		st_we    = 1'b0;
		st_wv    = BUF_IDLE;
		dat_we   = 1'b0;
		dat_wd   = '0;
		push     = 1'b0;
		main_pop = 1'b0;
		fill_pop = 1'b0;
		seq_inc  = 1'b0;
		go_walk  = 1'b0;
		en_set   = 1'b0;
		case (op_q)
			OP_QUEUE: begin
				if (!kind_q || !idx_ok || st_s2 != BUF_IDLE) begin
					o_status = ST_INVALID;
				end else if (disc_dev_q) begin
					o_status = ST_NODEV;
				end else begin
					st_we  = 1'b1;
					st_wv  = BUF_QUEUED;
					dat_we = 1'b1;
					dat_wd = {seq_r, {LB{1'b0}}};
					push   = 1'b1;
				end
			end
			OP_DEQUEUE: begin
				if (!kind_q || main_lvl_q == '0 || st_s2 == BUF_IDLE) begin
					o_status = ST_INVALID;
				end else if (st_s2 == BUF_QUEUED) begin
					o_status = ST_WOULDBLOCK;
				end else begin
					o_status = (st_s2 == BUF_ERROR) ? ST_IOERR : ST_OK;
					st_we    = 1'b1;
					st_wv    = BUF_IDLE;
					main_pop = 1'b1;
					o_idx    = idx4(b_s2);
					o_iv     = 1'b1;
					o_fill   = len24(fill_r);
					o_seq    = seq_r;
				end
			end
			OP_QUERY: begin
				if (!idx_ok) begin
					o_status = ST_INVALID;
				end else begin
					o_idx  = idx4(b_s2);
					o_iv   = 1'b1;
					o_fill = len24(fill_r);
					o_seq  = seq_r;
					o_fd   = (st_s2 == BUF_DONE) || (st_s2 == BUF_ERROR);
					o_fq   = (st_s2 == BUF_QUEUED);
				end
			end
			OP_POLL: begin
				if (main_lvl_q == '0)
					o_pe = 1'b1;
				else
					o_pr = (st_s2 == BUF_DONE) || (st_s2 == BUF_ERROR);
			end
			OP_FDONE: begin
				if (fill_lvl_q == '0) begin
					o_status = ST_NOBUF;
				end else if (drop_q && flen_m != bytes_q) begin
					st_we  = 1'b1;
					st_wv  = BUF_QUEUED;
					dat_we = 1'b1;
					dat_wd = {seq_r, {LB{1'b0}}};
					o_fill = len24(bytes_q);
					o_idx  = idx4(b_s2);
					o_iv   = 1'b1;
					o_fq   = 1'b1;
				end else begin
					st_we    = 1'b1;
					st_wv    = ferr_q ? BUF_ERROR : BUF_DONE;
					dat_we   = 1'b1;
					dat_wd   = {seqc_q, bytes_q};
					fill_pop = 1'b1;
					seq_inc  = 1'b1;
					o_fill   = len24(bytes_q);
					o_seq    = seqc_q;
					o_fd     = 1'b1;
					if (fill_lvl_q != LW'(1)) begin
						o_idx = idx4(fill_rd);
						o_iv  = 1'b1;
					end
				end
			end
			OP_ENABLE: begin
				if (stream_q)
					o_status = ST_BUSY;
				else
					en_set = 1'b1;
			end
			default: go_walk = 1'b1;
		endcase
	end

	// Memories: FIFO entries and per-buffer fill and sequence words.
	always_ff @(posedge clk) begin
		main_rd <= main_mem[main_head_q];
		fill_rd <= fill_mem[fill_raddr];
		dat_rd  <= dat_mem[b_sel];
		if (state_q == S_EX && push) begin
			main_mem[tail_of(main_head_q, main_lvl_q)] <= idx_w;
			fill_mem[tail_of(fill_head_q, fill_lvl_q)] <= idx_w;
		end
		if (state_q == S_EX && dat_we)
			dat_mem[b_s2] <= dat_wd;
	end

	// Sequencer, buffer state and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			flen_q      <= '0;
			drop_q      <= 1'b0;
			state_q     <= S_IDLE;
			main_head_q <= '0;
			fill_head_q <= '0;
			main_lvl_q  <= '0;
			fill_lvl_q  <= '0;
			seqc_q      <= '0;
			stream_q    <= 1'b0;
			disc_dev_q  <= 1'b0;
			vld_q       <= '0;
			for (int i = 0; i < NUM_BUFFERS; i++)
				bstate_q[i] <= BUF_IDLE;
			op_q        <= OP_QUEUE;
			idx_q       <= '0;
			kind_q      <= 1'b0;
			ferr_q      <= 1'b0;
			disc_q      <= 1'b0;
			bytes_q     <= '0;
			b_s2        <= '0;
			st_s2       <= BUF_IDLE;
			dvld_s2     <= 1'b0;
			wk_q        <= '0;
			wp_q        <= '0;
			pend_s1     <= 1'b0;
			done        <= 1'b0;
			status      <= ST_OK;
			result_index <= '0;
			index_valid <= 1'b0;
			filled_bytes <= '0;
			frame_sequence <= '0;
			flag_done   <= 1'b0;
			flag_queued <= 1'b0;
			poll_readable <= 1'b0;
			poll_error  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_COUNT:  count_q <= cfg_data[4:0];
					REG_LENGTH: flen_q  <= cfg_data;
					REG_DROP:   drop_q  <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					// The done strobe lasts the one idle cycle after a result.
					done <= 1'b0;
					if (start) begin
						op_q    <= op_t'(opcode);
						idx_q   <= buffer_index;
						kind_q  <= kind_ok;
						ferr_q  <= frame_error;
						disc_q  <= disconnect;
						bytes_q <= bytes_x[LB-1:0];
						state_q <= S_RD;
					end
				end
				S_RD: begin
					b_s2    <= b_sel;
					st_s2   <= bstate_q[b_sel];
					dvld_s2 <= vld_q[b_sel];
					state_q <= S_EX;
				end
				S_EX: begin
					if (st_we)
						bstate_q[b_s2] <= st_wv;
					if (dat_we)
						vld_q[b_s2] <= 1'b1;
					if (push) begin
						if (main_lvl_q != FULL_LVL)
							main_lvl_q <= main_lvl_q + 1'b1;
						if (fill_lvl_q != FULL_LVL)
							fill_lvl_q <= fill_lvl_q + 1'b1;
					end
					if (main_pop) begin
						main_head_q <= inc_wrap(main_head_q);
						main_lvl_q  <= main_lvl_q - 1'b1;
					end
					if (fill_pop) begin
						fill_head_q <= inc_wrap(fill_head_q);
						fill_lvl_q  <= fill_lvl_q - 1'b1;
					end
					if (seq_inc)
						seqc_q <= seqc_q + 32'd1;
					if (en_set) begin
						seqc_q   <= '0;
						stream_q <= 1'b1;
					end
					if (go_walk) begin
						wk_q    <= '0;
						wp_q    <= fill_head_q;
						pend_s1 <= 1'b0;
						state_q <= S_WALK;
					end else begin
						done           <= 1'b1;
						status         <= o_status;
						result_index   <= o_idx;
						index_valid    <= o_iv;
						filled_bytes   <= o_fill;
						frame_sequence <= o_seq;
						flag_done      <= o_fd;
						flag_queued    <= o_fq;
						poll_readable  <= o_pr;
						poll_error     <= o_pe;
						state_q        <= S_IDLE;
					end
				end
				S_WALK: begin
					// Issue one fill FIFO read a cycle, mark the buffer in the cycle after.
					if (pend_s1)
						bstate_q[fill_rd] <= BUF_ERROR;
					if (wk_q != fill_lvl_q) begin
						wk_q    <= wk_q + 1'b1;
						wp_q    <= inc_wrap(wp_q);
						pend_s1 <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1)
							state_q <= S_FIN;
					end
				end
				S_FIN: begin
					fill_head_q <= '0;
					fill_lvl_q  <= '0;
					if (op_q == OP_DISABLE) begin
						main_head_q <= '0;
						main_lvl_q  <= '0;
						stream_q    <= 1'b0;
						for (int i = 0; i < NUM_BUFFERS; i++)
							if (8'(i) < eff_cnt)
								bstate_q[i] <= BUF_IDLE;
					end else if (disc_q) begin
						disc_dev_q <= 1'b1;
					end
					done           <= 1'b1;
					status         <= ST_OK;
					result_index   <= '0;
					index_valid    <= 1'b0;
					filled_bytes   <= '0;
					frame_sequence <= '0;
					flag_done      <= 1'b0;
					flag_queued    <= 1'b0;
					poll_readable  <= 1'b0;
					poll_error     <= 1'b0;
					state_q        <= S_IDLE;
				end
				default: begin
					done    <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);

	// A result item only follows the execute or finish step.
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_EX || $past(state_q) == S_FIN))
		else $error("result item without a completed operation");

	// FIFO levels never exceed the number of buffers.
	a_levels: assert property (@(posedge clk) disable iff (!arst_n)
		(main_lvl_q <= FULL_LVL) && (fill_lvl_q <= FULL_LVL))
		else $error("FIFO level out of range");

	// No walk read is left pending once the block is idle.
	a_walk_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !pend_s1)
		else $error("cancel walk left a pending mark");

	// The fill FIFO is empty right after a cancel or disable item.
	a_fill_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> (fill_lvl_q == '0))
		else $error("fill FIFO not cleared");

endmodule
`default_nettype wire
